/* sv/seven_segment_number_formatter_defines.svh */
// Assertion macros for the seven-segment number formatter.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSNF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSNF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ssnf_pkg.sv */
// Types, codes and segment tables for the seven-segment number formatter.
// No dependencies.
package ssnf_pkg;

  localparam logic [2:0] CMD_UDEC = 3'd0;
  localparam logic [2:0] CMD_SDEC = 3'd1;
  localparam logic [2:0] CMD_HEXB = 3'd2;
  localparam logic [2:0] CMD_HEXW = 3'd3;
  localparam logic [2:0] CMD_ON   = 3'd4;
  localparam logic [2:0] CMD_OFF  = 3'd5;

  localparam logic [7:0] ADDR_BASE   = 8'hC0;
  localparam logic [7:0] SEG_BLANK   = 8'h00;
  localparam logic [7:0] SEG_DASH    = 8'h40;
  localparam logic [7:0] BYTE_ON_A   = 8'h02;
  localparam logic [7:0] BYTE_ON_B   = 8'h40;
  localparam logic [7:0] BYTE_BRIGHT = 8'h88;
  localparam logic [7:0] BYTE_OFF    = 8'h80;

  localparam int ValueBits = 16;
  localparam int BcdDigits = 5;
  localparam int BcdBits   = 4 * BcdDigits;
  localparam int AccBits   = BcdBits + ValueBits;
  localparam int DabSteps  = 4;
  localparam int DabStages = ValueBits / DabSteps;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       two_bytes;
    logic       last;
  } out_item_t;

  // Item in flight through the conversion stages: acc is {bcd, binary}.
  typedef struct packed {
    logic [2:0]         cmd;
    logic               neg;
    logic [15:0]        raw;
    logic [AccBits-1:0] acc;
  } dab_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       two;
  } frame_t;

  function automatic logic [7:0] seg_of(input logic [3:0] nib);
    logic [7:0] s;
    unique case (nib)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h58;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      4'hf: s = 8'h71;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic frame_t seg_frame(input logic [1:0] pos, input logic [7:0] seg);
    frame_t f;
    f.first  = ADDR_BASE | {5'b0, pos, 1'b0};
    f.second = seg;
    f.two    = 1'b1;
    return f;
  endfunction

  function automatic frame_t cmd_frame(input logic [7:0] b);
    frame_t f;
    f.first  = b;
    f.second = 8'h00;
    f.two    = 1'b0;
    return f;
  endfunction

  // One double-dabble step: correct each BCD digit, then shift left.
  function automatic logic [AccBits-1:0] dab_shift(input logic [AccBits-1:0] x);
    logic [AccBits-1:0] y;
    y = x;
    for (int k = 0; k < BcdDigits; k++) begin
      if (y[ValueBits+4*k +: 4] >= 4'd5) begin
        y[ValueBits+4*k +: 4] = y[ValueBits+4*k +: 4] + 4'd3;
      end
    end
    return {y[AccBits-2:0], 1'b0};
  endfunction

endpackage

/* sv/ssnf_prep.sv */
// Entry stage: decodes the command and takes the magnitude of negative values.
// Depends on ssnf_pkg.
module ssnf_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  ssnf_pkg::in_item_t item_i,
  output logic              stall_o,
  output logic              valid_o,
  output ssnf_pkg::dab_t    data_o,
  input  logic              stall_i
);
  import ssnf_pkg::*;

  logic        valid_r;
  dab_t        data_r;
  dab_t        data_nxt;
  logic        neg;
  logic [15:0] mag;

  assign neg = (item_i.command == CMD_SDEC) && item_i.value[15];
  // -32768 wraps to 0x8000, which is the wanted magnitude
  assign mag = neg ? (~item_i.value + 16'd1) : item_i.value;

  always_comb begin
    data_nxt.cmd = item_i.command;
    data_nxt.neg = neg;
    data_nxt.raw = item_i.value;
    data_nxt.acc = {{BcdBits{1'b0}}, mag};
  end

  assign stall_o = valid_r && stall_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_o) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/ssnf_dabble.sv */
// One stage of the binary-to-BCD converter: a fixed number of double-dabble steps.
// Depends on ssnf_pkg and the formatter assertion macros.
`include "seven_segment_number_formatter_defines.svh"

module ssnf_dabble (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  ssnf_pkg::dab_t data_i,
  output logic           stall_o,
  output logic           valid_o,
  output ssnf_pkg::dab_t data_o,
  input  logic           stall_i
);
  import ssnf_pkg::*;

  logic valid_r;
  dab_t data_r;
  dab_t data_nxt;

  always_comb begin
    data_nxt = data_i;
    for (int s = 0; s < DabSteps; s++) begin
      data_nxt.acc = dab_shift(data_nxt.acc);
    end
  end

  assign stall_o = valid_r && stall_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_o) begin
      data_r <= data_nxt;
    end
  end

  // After each stage's shifts every BCD digit must stay a decimal digit.
  `SSNF_ASSERT_NOW(a_bcd_digits, valid_r,
                   (data_r.acc[19:16] <= 4'd9) && (data_r.acc[23:20] <= 4'd9) &&
                   (data_r.acc[27:24] <= 4'd9) && (data_r.acc[31:28] <= 4'd9) &&
                   (data_r.acc[35:32] <= 4'd9), "BCD digit out of range")

endmodule

/* sv/ssnf_emit.sv */
// Frame builder and sender: formats the converted item into up to four frames,
// holds them in a buffer and hands them out one per transfer. Depends on ssnf_pkg.
`include "seven_segment_number_formatter_defines.svh"

module ssnf_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  ssnf_pkg::dab_t      data_i,
  output logic                stall_o,
  input  logic [2:0]          brightness,
  output logic                out_valid,
  output ssnf_pkg::out_item_t out_data,
  input  logic                out_stall
);
  import ssnf_pkg::*;

  frame_t [3:0] fmt;
  logic   [2:0] fmt_cnt;
  logic   [3:0] d4, d3, d2, d1, d0;
  logic         force_all;
  logic         big, mid;

  logic         buf_valid_r;
  frame_t [3:0] frames_r;
  logic   [1:0] last_r;
  logic   [1:0] idx_r;
  logic         out_valid_r;
  out_item_t    out_r;

  logic out_free, send, send_last, buf_free, load;

  assign d4 = data_i.acc[35:32];
  assign d3 = data_i.acc[31:28];
  assign d2 = data_i.acc[27:24];
  assign d1 = data_i.acc[23:20];
  assign d0 = data_i.acc[19:16];
  assign force_all = (d4 != 4'd0);
  assign big = (d4 != 4'd0) || (d3 != 4'd0) || (d2 != 4'd0);
  assign mid = (d1 != 4'd0);

  always_comb begin
    fmt     = '0;
    fmt_cnt = 3'd0;
    unique case (data_i.cmd)
      CMD_UDEC, CMD_SDEC: begin
        fmt_cnt = 3'd4;
        if (data_i.neg) begin
          // dash first, then any blanks ahead of it, then the digits after it
          priority if (big) begin
            fmt[0] = seg_frame(2'd0, SEG_DASH);
            fmt[1] = seg_frame(2'd1, seg_of(d2));
            fmt[2] = seg_frame(2'd2, seg_of(d1));
          end else if (mid) begin
            fmt[0] = seg_frame(2'd1, SEG_DASH);
            fmt[1] = seg_frame(2'd0, SEG_BLANK);
            fmt[2] = seg_frame(2'd2, seg_of(d1));
          end else begin
            fmt[0] = seg_frame(2'd2, SEG_DASH);
            fmt[1] = seg_frame(2'd0, SEG_BLANK);
            fmt[2] = seg_frame(2'd1, SEG_BLANK);
          end
          fmt[3] = seg_frame(2'd3, seg_of(d0));
        end else begin
          // blank leading zeros unless the value overflowed four digits
          fmt[0] = seg_frame(2'd0, (!force_all && d3 == 4'd0) ? SEG_BLANK : seg_of(d3));
          fmt[1] = seg_frame(2'd1, (!force_all && d3 == 4'd0 && d2 == 4'd0) ?
                                   SEG_BLANK : seg_of(d2));
          fmt[2] = seg_frame(2'd2, (!force_all && d3 == 4'd0 && d2 == 4'd0 &&
                                    d1 == 4'd0) ? SEG_BLANK : seg_of(d1));
          fmt[3] = seg_frame(2'd3, seg_of(d0));
        end
      end
      CMD_HEXB: begin
        fmt_cnt = 3'd4;
        fmt[0]  = seg_frame(2'd0, SEG_BLANK);
        fmt[1]  = seg_frame(2'd1, SEG_BLANK);
        fmt[2]  = seg_frame(2'd2, seg_of(data_i.raw[7:4]));
        fmt[3]  = seg_frame(2'd3, seg_of(data_i.raw[3:0]));
      end
      CMD_HEXW: begin
        fmt_cnt = 3'd4;
        fmt[0]  = seg_frame(2'd0, seg_of(data_i.raw[15:12]));
        fmt[1]  = seg_frame(2'd1, seg_of(data_i.raw[11:8]));
        fmt[2]  = seg_frame(2'd2, seg_of(data_i.raw[7:4]));
        fmt[3]  = seg_frame(2'd3, seg_of(data_i.raw[3:0]));
      end
      CMD_ON: begin
        fmt_cnt = 3'd3;
        fmt[0]  = cmd_frame(BYTE_ON_A);
        fmt[1]  = cmd_frame(BYTE_ON_B);
        fmt[2]  = cmd_frame(BYTE_BRIGHT | {5'b0, brightness});
      end
      CMD_OFF: begin
        fmt_cnt = 3'd1;
        fmt[0]  = cmd_frame(BYTE_OFF);
      end
      default: begin
        fmt_cnt = 3'd0;
      end
    endcase
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign send      = buf_valid_r && out_free;
  assign send_last = send && (idx_r == last_r);
  assign buf_free  = !buf_valid_r || send_last;
  assign load      = valid_i && buf_free;
  assign stall_o   = valid_i && !buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      // drop unused command codes: they produce no frame
      buf_valid_r <= (fmt_cnt != 3'd0);
      idx_r       <= 2'd0;
    end else if (send) begin
      buf_valid_r <= !send_last;
      idx_r       <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frames_r <= fmt;
      last_r   <= 2'(fmt_cnt - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= send;
    end
  end

  always_ff @(posedge clk) begin
    if (send) begin
      out_r.first_byte  <= frames_r[idx_r].first;
      out_r.second_byte <= frames_r[idx_r].second;
      out_r.two_bytes   <= frames_r[idx_r].two;
      out_r.last        <= (idx_r == last_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SSNF_ASSERT_NOW(a_idx_bound, buf_valid_r, idx_r <= last_r, "frame index past last frame")
  `SSNF_ASSERT_NEXT(a_last_sent, send_last, out_valid_r && out_r.last, "last frame not flagged")
  `SSNF_ASSERT_NEXT(a_hold_idx, buf_valid_r && !out_free, $stable(idx_r) && buf_valid_r,
                    "frame buffer advanced while output blocked")

endmodule

/* sv/seven_segment_number_formatter.sv */
// Top level of the seven-segment number formatter: entry stage, BCD conversion
// stages, frame sender and the brightness register. Depends on ssnf_pkg.
//
//   channel | direction | handshake      | payload
//   in_     | input     | valid / stall  | in_item_t  {command, value}
//   out_    | output    | valid / stall  | out_item_t {first_byte, second_byte, two_bytes, last}
//   cfg_    | input     | valid / ready  | 3-bit brightness
//
// A command passes the entry stage and the conversion stages into the frame buffer; its
// frames go out through the output register on out_. The frame buffer sends one frame per
// cycle while out_ is not stalled; a number gives 4 frames, display-on 3, display-off 1.
// Stalls on out_ back up through every stage without loss; in_stall follows.
// Synchronous active-low reset clears all valid bits and sets brightness to 7.
module seven_segment_number_formatter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssnf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssnf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_data
);
  import ssnf_pkg::*;

  logic [2:0] brightness_r;

  logic                 prep_valid;
  dab_t                 prep_data;
  logic [DabStages:0]   dab_valid;
  dab_t [DabStages:0]   dab_data;
  logic [DabStages:0]   dab_stall;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 3'd7;
    end else if (cfg_valid && cfg_ready) begin
      brightness_r <= cfg_data;
    end
  end

  ssnf_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .item_i  (in_data),
    .stall_o (in_stall),
    .valid_o (prep_valid),
    .data_o  (prep_data),
    .stall_i (dab_stall[0])
  );

  assign dab_valid[0] = prep_valid;
  assign dab_data[0]  = prep_data;

  for (genvar g = 0; g < DabStages; g++) begin : g_dab
    ssnf_dabble u_dab (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dab_valid[g]),
      .data_i  (dab_data[g]),
      .stall_o (dab_stall[g]),
      .valid_o (dab_valid[g+1]),
      .data_o  (dab_data[g+1]),
      .stall_i (dab_stall[g+1])
    );
  end

  ssnf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (dab_valid[DabStages]),
    .data_i     (dab_data[DabStages]),
    .stall_o    (dab_stall[DabStages]),
    .brightness (brightness_r),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

endmodule

/* tb/display_frame_check.sv */
// Frame checker for the seven-segment number formatter: watches the command,
// frame and brightness channels, predicts the display frames and compares them.
// Depends on ssnf_pkg for the payload types and command codes.
module display_frame_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  ssnf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  ssnf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [2:0]          cfg_data,
  output int                  mismatches,
  output int                  pending,
  output int                  frames_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssnf_pkg::*;

  localparam logic [2:0] BRIGHTNESS_AT_RESET = 3'd7;

  localparam logic [7:0] DIGIT_SEG [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71
  };

  logic [2:0] level;
  out_item_t  frames_due[$];
  // The newest predicted frame is held back until the command is complete,
  // so that its last flag can be set.
  out_item_t  held;
  bit         have_held;

  function automatic void add_frame(input logic [7:0] a, input logic [7:0] b,
                                    input logic two);
    if (have_held) frames_due.push_back(held);
    held.first_byte  = a;
    held.second_byte = b;
    held.two_bytes   = two;
    held.last        = 1'b0;
    have_held = 1'b1;
  endfunction

  function automatic void add_seg(input int pos, input logic [7:0] seg);
    add_frame(ADDR_BASE + 8'(2 * pos), seg, 1'b1);
  endfunction

  // Digits from position start to 3; m is below 10000.
  function automatic void add_decimal(input int start, input int unsigned m,
                                      input bit force_digits, input bit blanks);
    int unsigned weight;
    bit shown;
    shown = force_digits;
    for (int pos = start; pos < 3; pos++) begin
      weight = (pos == 0) ? 1000 : (pos == 1) ? 100 : 10;
      if (m >= weight || shown) begin
        add_seg(pos, DIGIT_SEG[m / weight]);
        m = m % weight;
        shown = 1'b1;
      end else if (blanks) begin
        add_seg(pos, SEG_BLANK);
      end
    end
    add_seg(3, DIGIT_SEG[m]);
  endfunction

  function automatic void queue_frames_for(input in_item_t item);
    int unsigned v;
    int unsigned mag;
    int dash_pos;
    bit force_digits;
    v = item.value;
    if (item.command == CMD_SDEC && item.value[15]) begin
      mag = 32'h10000 - v;
      dash_pos = (mag >= 100) ? 0 : (mag >= 10) ? 1 : 2;
      force_digits = 1'b0;
      add_seg(dash_pos, SEG_DASH);
      for (int i = 0; i < dash_pos; i++) add_seg(i, SEG_BLANK);
      if (mag >= 10000) begin
        mag = mag % 10000;
        force_digits = 1'b1;
      end
      if (mag >= 1000) begin
        mag = mag % 1000;
        force_digits = 1'b1;
      end
      add_decimal(1, mag, force_digits, 1'b0);
    end else begin
      case (item.command)
        CMD_UDEC, CMD_SDEC: begin
          add_decimal(0, v % 10000, v >= 10000, 1'b1);
        end
        CMD_HEXB: begin
          add_seg(0, SEG_BLANK);
          add_seg(1, SEG_BLANK);
          add_seg(2, DIGIT_SEG[item.value[7:4]]);
          add_seg(3, DIGIT_SEG[item.value[3:0]]);
        end
        CMD_HEXW: begin
          add_seg(0, DIGIT_SEG[item.value[15:12]]);
          add_seg(1, DIGIT_SEG[item.value[11:8]]);
          add_seg(2, DIGIT_SEG[item.value[7:4]]);
          add_seg(3, DIGIT_SEG[item.value[3:0]]);
        end
        CMD_ON: begin
          add_frame(BYTE_ON_A, 8'h00, 1'b0);
          add_frame(BYTE_ON_B, 8'h00, 1'b0);
          add_frame(BYTE_BRIGHT | {5'b0, level}, 8'h00, 1'b0);
        end
        CMD_OFF: begin
          add_frame(BYTE_OFF, 8'h00, 1'b0);
        end
        default: begin
          // unused codes produce nothing
        end
      endcase
    end
    if (have_held) begin
      held.last = 1'b1;
      frames_due.push_back(held);
      have_held = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      level = BRIGHTNESS_AT_RESET;
      frames_due.delete();
      have_held = 1'b0;
      mismatches = 0;
      frames_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) level = cfg_data;
      if (out_valid && !out_stall) begin
        frames_checked++;
        if (frames_due.size() == 0) begin
          $error("unexpected frame: first_byte %h second_byte %h two_bytes %b last %b",
                 out_data.first_byte, out_data.second_byte, out_data.two_bytes,
                 out_data.last);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (out_data.first_byte !== want.first_byte) begin
            $error("first_byte: expected %h, got %h", want.first_byte, out_data.first_byte);
            mismatches++;
          end
          if (out_data.second_byte !== want.second_byte) begin
            $error("second_byte: expected %h, got %h", want.second_byte,
                   out_data.second_byte);
            mismatches++;
          end
          if (out_data.two_bytes !== want.two_bytes) begin
            $error("two_bytes: expected %b, got %b", want.two_bytes, out_data.two_bytes);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) queue_frames_for(in_data);
    end
    pending = frames_due.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the formatter testbench: clock, reset, command and brightness stimulus,
// random stalls on the frame channel and the verdict.
// Depends on ssnf_pkg, seven_segment_number_formatter and display_frame_check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssnf_pkg::*;

  localparam int PHASE_COMMANDS = 65;
  localparam int RANDOM_PHASES  = 6;
  localparam int SETTLE_CYCLES  = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = 3'd0;

  int  mismatches;
  int  pending;
  int  frames_checked;
  int  commands_sent = 0;
  int  random_sent = 0;
  int  settings_used = 1;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  int  stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  seven_segment_number_formatter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  display_frame_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  // Receiver: after each frame transfer, when rx_idle is set, hold off for a random number of cycles.
  always @(posedge clk) begin
    int hold;
    if (!rst_n) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) hold = rx_idle ? $urandom_range(0, 19) : 0;
      else hold = (stall_left > 0) ? stall_left - 1 : 0;
      stall_left <= hold;
      out_stall <= (hold != 0);
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [15:0] val);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.command <= cmd;
    in_data.value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    commands_sent++;
  endtask

  // Hold the sender until every predicted frame has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [2:0] lvl);
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [15:0] pick_value();
    int k;
    int b;
    k = $urandom_range(0, 9);
    b = 1;
    repeat ($urandom_range(1, 4)) b = b * 10;
    case (k)
      4: return 16'($urandom_range(0, 120));
      5: return 16'(b + int'($urandom_range(0, 2)) - 1);
      6: return 16'(-int'($urandom_range(1, 1100)));
      7: return 16'(-(b + int'($urandom_range(0, 2)) - 1));
      8: return 16'($urandom_range(32760, 32775));
      9: return 16'($urandom_range(0, 3)) ^ ($urandom_range(0, 1) ? 16'h8000 : 16'hFFFF);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [2:0] cmd;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands at the reset brightness.
    send_command(CMD_UDEC, 16'd0);
    send_command(CMD_UDEC, 16'd10);
    send_command(CMD_UDEC, 16'd999);
    send_command(CMD_UDEC, 16'd9999);
    send_command(CMD_UDEC, 16'd10000);
    send_command(CMD_UDEC, 16'hFFFF);
    send_command(CMD_SDEC, 16'h7FFF);
    send_command(CMD_SDEC, 16'hFFFF);
    send_command(CMD_SDEC, 16'(-10));
    send_command(CMD_SDEC, 16'(-99));
    send_command(CMD_SDEC, 16'(-100));
    send_command(CMD_SDEC, 16'(-1000));
    send_command(CMD_SDEC, 16'(-10000));
    send_command(CMD_SDEC, 16'h8000);
    send_command(CMD_HEXB, 16'hA5C3);
    send_command(CMD_HEXB, 16'h00F0);
    send_command(CMD_HEXW, 16'h0123);
    send_command(CMD_HEXW, 16'h4567);
    send_command(CMD_HEXW, 16'h89AB);
    send_command(CMD_HEXW, 16'hCDEF);
    send_command(CMD_ON, 16'h0000);
    send_command(CMD_OFF, 16'hFFFF);
    send_command(3'd6, 16'h1234);
    send_command(3'd7, 16'h5678);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_brightness(3'd0);
        1: set_brightness(3'd7);
        2: set_brightness(3'd5);
        3: set_brightness(3'd2);
        default: set_brightness(3'($urandom_range(0, 7)));
      endcase
      tx_idle = (p != 1 && p != 3);
      rx_idle = (p != 2 && p != 3);
      for (int n = 0; n < PHASE_COMMANDS; ) begin
        if ($urandom_range(0, 99) < 4) begin
          cmd = 3'($urandom_range(6, 7));
        end else begin
          cmd = 3'($urandom_range(0, 5));
          n++;
          random_sent++;
        end
        send_command(cmd, pick_value());
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    $display("Sent %0d commands (%0d random) under %0d brightness settings.",
             commands_sent, random_sent, settings_used);
    $display("Checked %0d display frames against the predicted sequence.", frames_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d display frames outstanding", pending);
    $display("FAIL");
    $finish;
  end

endmodule
